>>> rtl/core/ifg_pkg.sv
// Shared constants and controller/datapath interface types for the IPv4 fragment header generator.
`timescale 1ns / 1ps
`default_nettype none

package ifg_pkg;

   // Default link MTU in bytes.
   localparam int IFG_MTU_DEFAULT = 1500;

   // Fixed header properties.
   localparam int          IFG_HDR_BYTES   = 20;
   localparam int          IFG_MAX_PAYLOAD = 65515;
   localparam int          IFG_MAX_FRAGS   = 45;
   localparam logic [15:0] IFG_VER_IHL_TOS = 16'h4500;
   localparam logic [7:0]  IFG_TTL         = 8'd64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;   // capture a new request
      logic load_base;  // build the per-packet partial checksum
      logic emit;       // load the next fragment header into the output register
   } ifg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frag_last;  // the pending fragment is the final one of the packet
   } ifg_sts_type;

endpackage : ifg_pkg

`default_nettype wire

>>> rtl/core/ipv4_fragment_header_generator.sv
// Top level of the IPv4 fragment header generator: controller, datapath and checks.
//
// Usage: a request transaction on the req_ channel names one packet (payload
// length, destination, protocol). The block answers with one rsp_ transaction
// per fragment, in order of rising payload offset, with rsp_last on the final
// one. The user must write the source address through the csr_ channel only
// while idle; the block does not enforce this, and csr_ready is always high.
// After acceptance the controller builds the partial checksum in S_BASE,
// then walks the fragments in S_WALK. Headers follow one per cycle while the
// output register is free (at most 45 fragments with the default MTU). The
// rate is set by the fragment walk, which builds one header per cycle when not stalled.
// req_stall is high from the cycle after acceptance until the last header
// has entered the output register; a new request may be taken while that
// header still waits. When rsp_stall is high while a header is shown, the output
// register holds and the walk pauses. Reset clears the identification
// counter, the source address and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_fragment_header_generator
   import ifg_pkg::*;
#(
   parameter int MTU_BYTES = IFG_MTU_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_source_ip,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_payload_length,
   input  wire logic [31:0] req_dest_ip,
   input  wire logic [7:0]  req_proto_number,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_total_length,
   output logic [15:0]      rsp_ident,
   output logic [13:0]      rsp_frag_field,
   output logic [15:0]      rsp_header_checksum,
   output logic [7:0]       rsp_out_proto,
   output logic [31:0]      rsp_out_dest_ip,
   output logic [15:0]      rsp_payload_offset,
   output logic [10:0]      rsp_fragment_bytes,
   output logic             rsp_last
);

   ifg_cmd_type cmd;
   ifg_sts_type sts;

   // The source address register accepts a write in any cycle.
   assign csr_ready = 1'b1;

   // Sequencing.
   ifg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Header computation and output register.
   ifg_dp #(
      .MTU_BYTES (MTU_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_write           (csr_valid && csr_ready),
      .csr_source_ip       (csr_source_ip),
      .req_payload_length  (req_payload_length),
      .req_dest_ip         (req_dest_ip),
      .req_proto_number    (req_proto_number),
      .rsp_total_length    (rsp_total_length),
      .rsp_ident           (rsp_ident),
      .rsp_frag_field      (rsp_frag_field),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_out_proto       (rsp_out_proto),
      .rsp_out_dest_ip     (rsp_out_dest_ip),
      .rsp_payload_offset  (rsp_payload_offset),
      .rsp_fragment_bytes  (rsp_fragment_bytes),
      .rsp_last            (rsp_last)
   );

`ifndef SYNTHESIS
   // An accepted request makes the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req_stall low right after a request transaction");

   // While a non-final header is shown, the walk is still in progress.
   a_busy_mid_packet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request accepted in the middle of a packet");

   // A drained non-final header is followed at once by the next one.
   a_next_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last && !rsp_stall) |=> rsp_valid)
      else $error("gap between fragment headers of one packet");

   // Fragment offsets advance by the previous fragment's size.
   a_offset_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last && !rsp_stall) |=>
      (rsp_payload_offset ==
       16'($past(rsp_payload_offset) + {5'b0, $past(rsp_fragment_bytes)})))
      else $error("fragment offset does not follow the previous fragment");
`endif

endmodule : ipv4_fragment_header_generator

`default_nettype wire

>>> rtl/core/ifg_ctrl.sv
// Controller state machine that sequences request capture and the fragment walk.
`timescale 1ns / 1ps
`default_nettype none

module ifg_ctrl
   import ifg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output ifg_cmd_type      cmd,
   input  wire ifg_sts_type sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_BASE,
      S_WALK
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // The output register can take a new header when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Commands decoded from the current state.
   assign req_stall     = (state_ff != S_IDLE);
   assign cmd.load_req  = (state_ff == S_IDLE) && req_valid;
   assign cmd.load_base = (state_ff == S_BASE);
   assign cmd.emit      = (state_ff == S_WALK) && out_free;
   assign rsp_valid     = rsp_valid_ff;

   // State register and output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_BASE;
               end
            end
            S_BASE: begin
               state_ff <= S_WALK;
            end
            S_WALK: begin
               if (out_free && sts.frag_last) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule : ifg_ctrl

`default_nettype wire

>>> rtl/core/ifg_dp.sv
// Datapath holding the request, offset walk, identification counter and output header register.
`timescale 1ns / 1ps
`default_nettype none

module ifg_dp
   import ifg_pkg::*;
#(
   parameter int MTU_BYTES = IFG_MTU_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ifg_cmd_type cmd,
   output ifg_sts_type      sts,
   input  wire logic        csr_write,
   input  wire logic [31:0] csr_source_ip,
   input  wire logic [15:0] req_payload_length,
   input  wire logic [31:0] req_dest_ip,
   input  wire logic [7:0]  req_proto_number,
   output logic [15:0]      rsp_total_length,
   output logic [15:0]      rsp_ident,
   output logic [13:0]      rsp_frag_field,
   output logic [15:0]      rsp_header_checksum,
   output logic [7:0]       rsp_out_proto,
   output logic [31:0]      rsp_out_dest_ip,
   output logic [15:0]      rsp_payload_offset,
   output logic [10:0]      rsp_fragment_bytes,
   output logic             rsp_last
);

   // Largest fragment payload, a multiple of 8 bytes.
   localparam int ChunkBytes = (MTU_BYTES - IFG_HDR_BYTES) & ~7;
   localparam int CapBytes   = IFG_MAX_FRAGS * ChunkBytes;
   localparam int SatBytes   = (CapBytes < IFG_MAX_PAYLOAD) ? CapBytes : IFG_MAX_PAYLOAD;
   localparam logic [15:0] ChunkLen = 16'(ChunkBytes);
   localparam logic [15:0] SatLen   = 16'(SatBytes);
   localparam logic [15:0] HdrLen   = 16'(IFG_HDR_BYTES);

   logic [31:0] source_ip_ff;
   logic [15:0] ident_ff;
   logic [15:0] rest_ff;
   logic [15:0] off_ff;
   logic [31:0] dest_ff;
   logic [7:0]  proto_ff;
   logic [19:0] base_ff;

   logic [15:0] len_sat;
   logic        more;
   logic [15:0] cur_bytes;
   logic [15:0] tot;
   logic [13:0] frag;
   logic [19:0] sum_raw;
   logic [16:0] sum_fold1;
   logic [15:0] sum_fold2;

   // Saturate the requested payload length.
   assign len_sat = (req_payload_length > SatLen) ? SatLen : req_payload_length;

   // Current fragment fields.
   assign more      = (rest_ff > ChunkLen);
   assign cur_bytes = more ? ChunkLen : rest_ff;
   assign tot       = HdrLen + cur_bytes;
   assign frag      = {more, off_ff[15:3]};

   // Finish the checksum: add the per-fragment words and fold the carries twice.
   assign sum_raw   = base_ff + {4'b0, tot} + {6'b0, frag};
   assign sum_fold1 = {1'b0, sum_raw[15:0]} + {13'b0, sum_raw[19:16]};
   assign sum_fold2 = sum_fold1[15:0] + {15'b0, sum_fold1[16]};

   assign sts.frag_last = !more;

   // Configuration register and identification counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ip_ff <= '0;
         ident_ff     <= '0;
      end else begin
         if (csr_write) begin
            source_ip_ff <= csr_source_ip;
         end
         if (cmd.emit && !more) begin
            ident_ff <= ident_ff + 16'd1;
         end
      end
   end

   // Request capture, partial checksum and the offset walk.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rest_ff  <= len_sat;
         off_ff   <= '0;
         dest_ff  <= req_dest_ip;
         proto_ff <= req_proto_number;
      end else if (cmd.emit) begin
         rest_ff <= rest_ff - cur_bytes;
         off_ff  <= off_ff + cur_bytes;
      end
      if (cmd.load_base) begin
         base_ff <= {4'b0, IFG_VER_IHL_TOS} + {4'b0, ident_ff} + {4'b0, IFG_TTL, proto_ff}
                    + {4'b0, source_ip_ff[31:16]} + {4'b0, source_ip_ff[15:0]}
                    + {4'b0, dest_ff[31:16]} + {4'b0, dest_ff[15:0]};
      end
   end

   // Output header register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_total_length    <= tot;
         rsp_ident           <= ident_ff;
         rsp_frag_field      <= frag;
         rsp_header_checksum <= ~sum_fold2;
         rsp_out_proto       <= proto_ff;
         rsp_out_dest_ip     <= dest_ff;
         rsp_payload_offset  <= off_ff;
         rsp_fragment_bytes  <= cur_bytes[10:0];
         rsp_last            <= !more;
      end
   end

endmodule : ifg_dp

`default_nettype wire
